### rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lfn_pkg.sv
// Types and constants shared by the line follow navigator modules.
package lfn_pkg;

    localparam int LEVEL_W    = 8;
    localparam int NODE_W     = 4;
    localparam int OVER_W     = 10;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_FOLLOW = 2'd1,
        CMD_LEFT   = 2'd2,
        CMD_RIGHT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MOT_STOP  = 3'd0,
        MOT_FWD   = 3'd1,
        MOT_SOFTL = 3'd2,
        MOT_SOFTR = 3'd3,
        MOT_SPINL = 3'd4,
        MOT_SPINR = 3'd5
    } t_motor;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT = 2'd2;

    localparam logic [LEVEL_W-1:0] LINE_THR_RST  = 8'd200;
    localparam logic [LEVEL_W-1:0] OBST_LIM_RST  = 8'd90;
    localparam logic [OVER_W-1:0]  OVERSHOOT_RST = 10'd330;

    typedef struct packed {
        t_cmd                cmd;
        logic [LEVEL_W-1:0]  left_level;
        logic [LEVEL_W-1:0]  mid_level;
        logic [LEVEL_W-1:0]  right_level;
        logic [LEVEL_W-1:0]  distance;
        logic [NODE_W-1:0]   node_target;
    } t_item;

    typedef struct packed {
        t_motor motor;
        logic   busy_res;
        logic   done_res;
        logic   obstacle;
    } t_res;

    typedef struct packed {
        logic [LEVEL_W-1:0] line_threshold;
        logic [LEVEL_W-1:0] obstacle_limit;
        logic [OVER_W-1:0]  overshoot_ticks;
    } t_cfg;

endpackage

### rtl/lfn_cfg.sv
// Configuration register file: line threshold, obstacle limit, overshoot ticks.
module lfn_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lfn_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [lfn_pkg::CFG_DATA_W-1:0] i_data,
    output lfn_pkg::t_cfg                  o_cfg
);
    import lfn_pkg::*;

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_threshold  <= LINE_THR_RST;
            r_cfg.obstacle_limit  <= OBST_LIM_RST;
            r_cfg.overshoot_ticks <= OVERSHOOT_RST;
        end else if (i_valid) begin
            case (i_index)
                CFG_LINE_THR:  r_cfg.line_threshold  <= i_data[LEVEL_W-1:0];
                CFG_OBST_LIM:  r_cfg.obstacle_limit  <= i_data[LEVEL_W-1:0];
                CFG_OVERSHOOT: r_cfg.overshoot_ticks <= i_data[OVER_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/lfn_seq.sv
// Motion sequencer: mode state, node counting, obstacle hold and result register.
module lfn_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lfn_pkg::t_item i_item,
    input  lfn_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output lfn_pkg::t_res  o_res
);
    import lfn_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_FOLLOW = 3'd1,
        MODE_LEAVE  = 3'd2,
        MODE_OVER   = 3'd3,
        MODE_LA     = 3'd4,
        MODE_LB     = 3'd5,
        MODE_RA     = 3'd6,
        MODE_RB     = 3'd7
    } t_mode;

    t_mode              r_mode, n_mode;
    logic               r_hold, n_hold;
    logic               r_on_node, n_on_node;
    logic [NODE_W-1:0]  r_nodes, n_nodes;
    logic [NODE_W-1:0]  r_target, n_target;
    logic [OVER_W-1:0]  r_over, n_over;
    logic               r_valid;
    t_res               r_res, n_res;

    logic               w_adv;
    logic               w_l, w_m, w_r;
    logic               w_side;
    logic [NODE_W-1:0]  w_nodes_inc;

    assign o_ready = !r_valid || i_ready;
    assign w_adv   = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    assign w_l = i_item.left_level  >= i_cfg.line_threshold;
    assign w_m = i_item.mid_level   >= i_cfg.line_threshold;
    assign w_r = i_item.right_level >= i_cfg.line_threshold;

    always_comb begin
        n_mode    = r_mode;
        n_hold    = r_hold;
        n_on_node = r_on_node;
        n_nodes   = r_nodes;
        n_target  = r_target;
        n_over    = r_over;
        n_res     = '0;
        n_res.motor = MOT_STOP;
        w_side      = 1'b0;
        w_nodes_inc = r_nodes + 1'b1;

        // a command restarts the motion and uses its own samples as the first tick
        case (i_item.cmd)
            CMD_FOLLOW: begin
                n_hold    = 1'b0;
                n_mode    = MODE_FOLLOW;
                n_on_node = 1'b0;
                n_nodes   = '0;
                n_target  = (i_item.node_target == '0) ? NODE_W'(1) : i_item.node_target;
            end
            CMD_LEFT: begin
                n_hold = 1'b0;
                n_mode = MODE_LA;
            end
            CMD_RIGHT: begin
                n_hold = 1'b0;
                n_mode = MODE_RA;
            end
            default: ;
        endcase
        w_nodes_inc = n_nodes + 1'b1;

        case (n_mode)
            MODE_FOLLOW: begin
                if (i_item.distance != '0 && i_item.distance < i_cfg.obstacle_limit) begin
                    n_hold = 1'b1;
                end else if (n_hold) begin
                    if (i_item.distance == '0) n_hold = 1'b0;
                end else if (w_l && w_m && w_r) begin
                    // count only the entry onto a node
                    if (!n_on_node) begin
                        n_on_node = 1'b1;
                        n_nodes   = w_nodes_inc;
                        if (w_nodes_inc == n_target) begin
                            n_mode      = MODE_LEAVE;
                            n_res.motor = MOT_FWD;
                        end
                    end
                end else begin
                    n_on_node = 1'b0;
                    if (!w_l && w_m && !w_r)  n_res.motor = MOT_FWD;
                    else if (w_l && !w_r)     n_res.motor = MOT_SOFTL;
                    else if (!w_l && w_r)     n_res.motor = MOT_SOFTR;
                end
            end
            MODE_LEAVE: begin
                if (w_l && w_m && w_r) begin
                    n_res.motor = MOT_FWD;
                end else if (i_cfg.overshoot_ticks == '0) begin
                    n_mode         = MODE_IDLE;
                    n_over         = '0;
                    n_res.done_res = 1'b1;
                end else begin
                    n_mode      = MODE_OVER;
                    n_over      = i_cfg.overshoot_ticks - 1'b1;
                    n_res.motor = MOT_FWD;
                end
            end
            MODE_OVER: begin
                if (r_over == '0) begin
                    n_mode         = MODE_IDLE;
                    n_res.done_res = 1'b1;
                end else begin
                    n_over      = r_over - 1'b1;
                    n_res.motor = MOT_FWD;
                end
            end
            MODE_LA, MODE_RA: begin
                w_side      = (n_mode == MODE_LA) ? w_l : w_r;
                n_res.motor = (n_mode == MODE_LA) ? MOT_SPINL : MOT_SPINR;
                // middle and spin-side sensors both light: second phase, still spinning this tick
                if (!(w_m || w_side)) n_mode = (n_mode == MODE_LA) ? MODE_LB : MODE_RB;
            end
            MODE_LB, MODE_RB: begin
                if (!w_m) begin
                    n_res.motor = (n_mode == MODE_LB) ? MOT_SPINL : MOT_SPINR;
                end else begin
                    n_mode         = MODE_IDLE;
                    n_res.done_res = 1'b1;
                end
            end
            default: ;
        endcase

        n_res.busy_res = (n_mode != MODE_IDLE);
        n_res.obstacle = n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_hold    <= 1'b0;
            r_on_node <= 1'b0;
            r_nodes   <= '0;
            r_target  <= NODE_W'(1);
            r_over    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (o_ready) r_valid <= i_valid;
            if (w_adv) begin
                r_mode    <= n_mode;
                r_hold    <= n_hold;
                r_on_node <= n_on_node;
                r_nodes   <= n_nodes;
                r_target  <= n_target;
                r_over    <= n_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_res <= n_res;
    end

endmodule

### rtl/line_follow_navigator_core.sv
// Top level of the line follow navigator: input register, config, sequencer.
// A result passes the input register and then the result register before it is valid.
// Throughput: one item per cycle unless stalled; each tick's state update is combinational.
// s_axis_tready drops only when both the input and the result register are full and stalled.
// Reset (i_rst_n low, synchronous): idle mode, obstacle hold clear, target one, config defaults.
module line_follow_navigator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] left_level, [15:8] mid_level, [23:16] right_level, [31:24] distance,
    // [35:32] node_target, [39:36] zero
    input  logic [lfn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [lfn_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] motor, [3] busy_res, [4] done_res, [5] obstacle, [7:6] zero
    output logic [lfn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lfn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lfn_pkg::*;

    logic  r_in_valid;
    t_item r_in;
    t_item w_item;
    t_cfg  w_cfg;
    t_res  w_res;
    logic  w_seq_ready;

    assign w_item.cmd         = t_cmd'(s_axis_tuser);
    assign w_item.left_level  = s_axis_tdata[7:0];
    assign w_item.mid_level   = s_axis_tdata[15:8];
    assign w_item.right_level = s_axis_tdata[23:16];
    assign w_item.distance    = s_axis_tdata[31:24];
    assign w_item.node_target = s_axis_tdata[35:32];

    assign s_axis_tready = !r_in_valid || w_seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in <= w_item;
    end

    lfn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lfn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (w_seq_ready),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {2'b00, w_res.obstacle, w_res.done_res, w_res.busy_res, w_res.motor};

endmodule

### rtl/lfn_chk.sv
// Port-level assertion checker for the line follow navigator, bound to the top level.
`include "assert_macros.svh"

module lfn_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lfn_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lfn_pkg::*;

    logic w_busy, w_done, w_obst, w_stop;

    assign w_busy = m_axis_tdata[3];
    assign w_done = m_axis_tdata[4];
    assign w_obst = m_axis_tdata[5];
    assign w_stop = (m_axis_tdata[2:0] == MOT_STOP);

    // a finished motion leaves the block idle
    `LFN_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, m_axis_tvalid && w_done, !w_busy, "done with busy")
    // a finishing tick never drives the motors
    `LFN_ASSERT_IMP(a_done_stops, i_clk, i_rst_n, m_axis_tvalid && w_done, w_stop, "done while moving")
    // the obstacle hold only exists inside a follow motion and halts it
    `LFN_ASSERT_IMP(a_obst_stops, i_clk, i_rst_n, m_axis_tvalid && w_obst, w_stop && w_busy, "hold moving")
    `LFN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind line_follow_navigator_core lfn_chk u_lfn_chk (.*);

### dv/lfn_nav_checker.sv
// Scoreboard for the line follow navigator: predicts every result and compares each transfer.
module lfn_nav_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [lfn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [lfn_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [lfn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [lfn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfn_pkg::*;

    typedef enum logic [2:0] {
        NAV_IDLE,
        NAV_FOLLOW,
        NAV_LEAVE,
        NAV_OVER,
        NAV_SPIN_L1,
        NAV_SPIN_L2,
        NAV_SPIN_R1,
        NAV_SPIN_R2
    } t_nav_mode;

    t_nav_mode          nav_mode;
    logic               hold_q;
    logic               on_node_q;
    logic [NODE_W-1:0]  nodes_seen;
    logic [NODE_W-1:0]  nodes_goal;
    logic [OVER_W-1:0]  over_left;

    logic [LEVEL_W-1:0] thr_q;
    logic [LEVEL_W-1:0] lim_q;
    logic [OVER_W-1:0]  over_cfg;

    t_res motion_q[$];
    int   mismatches = 0;
    int   queued     = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    // One tick of the overshoot run: forward while ticks remain, else stop and finish.
    function automatic void overshoot_tick(inout t_res res);
        if (over_left == '0) begin
            nav_mode     = NAV_IDLE;
            res.done_res = 1'b1;
            res.motor    = MOT_STOP;
        end else begin
            over_left = over_left - 1'b1;
            res.motor = MOT_FWD;
        end
    endfunction

    function automatic t_res predict_tick(t_item it);
        t_res res;
        logic dk_l;
        logic dk_m;
        logic dk_r;
        logic side;
        dk_l         = it.left_level >= thr_q;
        dk_m         = it.mid_level >= thr_q;
        dk_r         = it.right_level >= thr_q;
        res.motor    = MOT_STOP;
        res.done_res = 1'b0;

        // any command drops the running motion and clears the obstacle hold
        if (it.cmd != CMD_TICK) begin
            hold_q = 1'b0;
            if (it.cmd == CMD_FOLLOW) begin
                nav_mode   = NAV_FOLLOW;
                on_node_q  = 1'b0;
                nodes_seen = '0;
                nodes_goal = (it.node_target == '0) ? 4'd1 : it.node_target;
            end else begin
                nav_mode = (it.cmd == CMD_LEFT) ? NAV_SPIN_L1 : NAV_SPIN_R1;
            end
        end

        case (nav_mode)
            NAV_FOLLOW: begin
                if (it.distance != '0 && it.distance < lim_q) begin
                    hold_q = 1'b1;
                end else if (hold_q) begin
                    if (it.distance == '0) hold_q = 1'b0;
                end else if (dk_l && dk_m && dk_r) begin
                    // count a node only on entry
                    if (!on_node_q) begin
                        on_node_q  = 1'b1;
                        nodes_seen = nodes_seen + 1'b1;
                        if (nodes_seen == nodes_goal) begin
                            nav_mode  = NAV_LEAVE;
                            res.motor = MOT_FWD;
                        end
                    end
                end else begin
                    on_node_q = 1'b0;
                    if (!dk_l && dk_m && !dk_r) res.motor = MOT_FWD;
                    else if (dk_l && !dk_r) res.motor = MOT_SOFTL;
                    else if (!dk_l && dk_r) res.motor = MOT_SOFTR;
                end
            end
            NAV_LEAVE: begin
                if (dk_l && dk_m && dk_r) begin
                    res.motor = MOT_FWD;
                end else begin
                    nav_mode  = NAV_OVER;
                    over_left = over_cfg;
                    overshoot_tick(res);
                end
            end
            NAV_OVER: overshoot_tick(res);
            NAV_SPIN_L1, NAV_SPIN_R1: begin
                side      = (nav_mode == NAV_SPIN_L1) ? dk_l : dk_r;
                res.motor = (nav_mode == NAV_SPIN_L1) ? MOT_SPINL : MOT_SPINR;
                // second phase starts on this very tick, still spinning
                if (!(dk_m || side))
                    nav_mode = (nav_mode == NAV_SPIN_L1) ? NAV_SPIN_L2 : NAV_SPIN_R2;
            end
            NAV_SPIN_L2, NAV_SPIN_R2: begin
                if (!dk_m) begin
                    res.motor = (nav_mode == NAV_SPIN_L2) ? MOT_SPINL : MOT_SPINR;
                end else begin
                    nav_mode     = NAV_IDLE;
                    res.done_res = 1'b1;
                end
            end
            default: ;
        endcase

        res.busy_res = (nav_mode != NAV_IDLE);
        res.obstacle = hold_q;
        return res;
    endfunction

    task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item it;
        t_res  got;
        t_res  want;
        if (!i_rst_n) begin
            nav_mode   = NAV_IDLE;
            hold_q     = 1'b0;
            on_node_q  = 1'b0;
            nodes_seen = '0;
            nodes_goal = 4'd1;
            over_left  = '0;
            thr_q      = LINE_THR_RST;
            lim_q      = OBST_LIM_RST;
            over_cfg   = OVERSHOOT_RST;
            motion_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.motor    = t_motor'(m_axis_tdata[2:0]);
                got.busy_res = m_axis_tdata[3];
                got.done_res = m_axis_tdata[4];
                got.obstacle = m_axis_tdata[5];
                if (motion_q.size() == 0) begin
                    $error("result transfer with nothing expected: motor %0d busy %0b done %0b obstacle %0b",
                           got.motor, got.busy_res, got.done_res, got.obstacle);
                    mismatches++;
                end else begin
                    want = motion_q.pop_front();
                    check_field("motor", want.motor, got.motor);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("obstacle", want.obstacle, got.obstacle);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_THR:  thr_q    = i_cfg_data[LEVEL_W-1:0];
                    CFG_OBST_LIM:  lim_q    = i_cfg_data[LEVEL_W-1:0];
                    CFG_OVERSHOOT: over_cfg = i_cfg_data[OVER_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.cmd         = t_cmd'(s_axis_tuser);
                it.left_level  = s_axis_tdata[7:0];
                it.mid_level   = s_axis_tdata[15:8];
                it.right_level = s_axis_tdata[23:16];
                it.distance    = s_axis_tdata[31:24];
                it.node_target = s_axis_tdata[35:32];
                motion_q.push_back(predict_tick(it));
            end
        end
        queued = motion_q.size();
    end

endmodule

### dv/tb_line_follow_navigator_core.sv
// Testbench top for the line follow navigator: stimulus, handshake idling and verdict.
module tb_line_follow_navigator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lfn_pkg::*;

    // sensor dark masks: bit 2 left, bit 1 middle, bit 0 right
    localparam logic [2:0] DK_NONE = 3'b000;
    localparam logic [2:0] DK_R    = 3'b001;
    localparam logic [2:0] DK_M    = 3'b010;
    localparam logic [2:0] DK_MR   = 3'b011;
    localparam logic [2:0] DK_L    = 3'b100;
    localparam logic [2:0] DK_LR   = 3'b101;
    localparam logic [2:0] DK_LM   = 3'b110;
    localparam logic [2:0] DK_ALL  = 3'b111;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int           fail_count;
    int           pending;
    bit           idle_en = 1'b1;
    int           rx_hold_req = 0;
    logic [7:0]   thr_now = LINE_THR_RST;
    logic [7:0]   lim_now = OBST_LIM_RST;

    line_follow_navigator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lfn_nav_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[line_follow_navigator_core] ERROR");
        $finish;
    end

    // Result side: short random stalls, or a long hold-off when requested.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Pick a level on the requested side of the threshold, often right at the boundary.
    function automatic logic [7:0] pick_level(bit dark);
        int p;
        p = $urandom_range(0, 7);
        if (dark || thr_now == 8'd0) begin
            if (p == 0) return 8'hFF;
            if (p < 3) return thr_now;
            return 8'($urandom_range(thr_now, 255));
        end
        if (p == 0) return 8'h00;
        if (p < 3) return thr_now - 8'd1;
        return 8'($urandom_range(0, thr_now - 1));
    endfunction

    function automatic t_item make_item(t_cmd c, logic [2:0] dk, logic [7:0] dist_in,
                                        logic [3:0] tgt);
        t_item it;
        it.cmd         = c;
        it.left_level  = pick_level(dk[2]);
        it.mid_level   = pick_level(dk[1]);
        it.right_level = pick_level(dk[0]);
        it.distance    = dist_in;
        it.node_target = tgt;
        return it;
    endfunction

    // Mostly plausible track patterns with an occasional command; some raw noise.
    function automatic t_item rand_item();
        t_item      it;
        int         p;
        logic [2:0] dk;
        logic [7:0] dist_v;
        t_cmd       c;
        logic [3:0] tgt;
        p = $urandom_range(0, 99);
        if (p < 30)      dk = DK_M;
        else if (p < 45) dk = $urandom_range(0, 1) ? DK_L : DK_LM;
        else if (p < 60) dk = $urandom_range(0, 1) ? DK_R : DK_MR;
        else if (p < 75) dk = DK_ALL;
        else if (p < 85) dk = DK_NONE;
        else             dk = 3'($urandom_range(0, 7));
        p = $urandom_range(0, 99);
        if (p < 70)                      dist_v = 8'd0;
        else if (p < 82 && lim_now > 1)  dist_v = 8'($urandom_range(1, lim_now - 1));
        else if (p < 95)                 dist_v = 8'($urandom_range(lim_now, 255));
        else                             dist_v = 8'($urandom_range(0, 255));
        c   = ($urandom_range(0, 11) == 0) ? t_cmd'($urandom_range(1, 3)) : CMD_TICK;
        tgt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 3));
        it = make_item(c, dk, dist_v, tgt);
        if ($urandom_range(0, 19) == 0) begin
            it.cmd         = t_cmd'($urandom_range(0, 3));
            it.left_level  = 8'($urandom_range(0, 255));
            it.mid_level   = 8'($urandom_range(0, 255));
            it.right_level = 8'($urandom_range(0, 255));
            it.distance    = 8'($urandom_range(0, 255));
            it.node_target = 4'($urandom_range(0, 15));
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_item(input t_item it);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.node_target, it.distance, it.right_level,
                          it.mid_level, it.left_level};
        s_axis_tuser  <= it.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result, plus the pipeline depth.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LINE_THR) thr_now = val[7:0];
        if (idx == CFG_OBST_LIM) lim_now = val[7:0];
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [7:0] lim,
                              input logic [9:0] over);
        write_reg(CFG_LINE_THR, {2'b0, thr});
        write_reg(CFG_OBST_LIM, {2'b0, lim});
        write_reg(CFG_OVERSHOOT, over);
    endtask

    task automatic run_random(input int n, input int hold_at, input int pause_at);
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) rx_hold_req = 48;
            if (k == pause_at) drain();
            push_item(rand_item());
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: idle extremes, steering, obstacle hold, node, overshoot, spins
        write_reg(CFG_OVERSHOOT, 10'd2);
        push_item('{CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0});
        push_item('{CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF});
        push_item(make_item(CMD_FOLLOW, DK_M, 8'd0, 4'd0));
        push_item(make_item(CMD_TICK, DK_L, 8'd90, 4'd1));
        push_item(make_item(CMD_TICK, DK_R, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_NONE, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_LR, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_M, 8'd1, 4'd1));
        push_item(make_item(CMD_TICK, DK_ALL, 8'd255, 4'd1));
        push_item(make_item(CMD_TICK, DK_ALL, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_ALL, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_ALL, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_M, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_M, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_M, 8'd0, 4'd1));
        push_item(make_item(CMD_LEFT, DK_M, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_NONE, 8'd0, 4'd1));
        push_item(make_item(CMD_TICK, DK_M, 8'd0, 4'd1));
        push_item(make_item(CMD_FOLLOW, DK_M, 8'd89, 4'd3));
        push_item(make_item(CMD_RIGHT, DK_R, 8'd89, 4'd3));
        push_item(make_item(CMD_TICK, DK_NONE, 8'd0, 4'd1));
        push_item(make_item(CMD_FOLLOW, DK_M, 8'd0, 4'd15));
        // zero overshoot and a zero obstacle limit
        write_reg(CFG_OVERSHOOT, 10'd0);
        write_reg(CFG_OBST_LIM, 10'd0);
        push_item(make_item(CMD_FOLLOW, DK_ALL, 8'd5, 4'd1));
        push_item(make_item(CMD_TICK, DK_NONE, 8'd5, 4'd1));

        set_config(8'd200, 8'd90, 10'd6);
        run_random(150, 40, 100);
        set_config(8'd0, 8'd255, 10'd0);
        run_random(40, -1, -1);
        set_config(8'd255, 8'd1, 10'd1023);
        run_random(50, -1, -1);
        set_config(8'd128, 8'd200, 10'd17);
        run_random(100, -1, 50);
        set_config(8'($urandom_range(50, 220)), 8'($urandom_range(1, 255)),
                   10'($urandom_range(0, 40)));
        run_random(100, -1, -1);
        idle_en = 1'b0;
        run_random(60, -1, -1);

        drain();
        repeat (6) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[line_follow_navigator_core] OK");
        end else begin
            $display("[line_follow_navigator_core] ERROR");
        end
        $finish;
    end

endmodule
